FILE: rtl/core/cau_pkg.sv
// Shared types, operation codes and the saturation helper of the complex arithmetic unit.
// No dependencies; every other file in rtl/core uses this package.
`timescale 1ns / 1ps

package cau_pkg;

  localparam int DATA_W = 16;
  localparam int FRAC_W = 8;
  localparam int PROD_W = 2 * DATA_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int QUO_W  = DATA_W - 1;
  localparam int DEN_W  = PROD_W;
  localparam int REM_W  = DEN_W + QUO_W + 1;
  localparam int LAT    = QUO_W + 2;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  typedef struct packed {
    logic [1:0]               operation;
    logic signed [DATA_W-1:0] a_real;
    logic signed [DATA_W-1:0] a_imag;
    logic signed [DATA_W-1:0] b_real;
    logic signed [DATA_W-1:0] b_imag;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_real;
    logic signed [DATA_W-1:0] result_imag;
    logic                     divide_by_zero;
  } out_item_t;

  typedef struct packed {
    logic [1:0]               op;
    logic signed [PROD_W-1:0] p_rr;
    logic signed [PROD_W-1:0] p_ii;
    logic signed [PROD_W-1:0] p_ri;
    logic signed [PROD_W-1:0] p_ir;
    logic signed [PROD_W-1:0] sq_r;
    logic signed [PROD_W-1:0] sq_i;
    logic signed [DATA_W:0]   s_re;
    logic signed [DATA_W:0]   s_im;
    logic                     b_zero;
  } prod_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic             neg;
    logic             sat;
  } lane_t;

  typedef struct packed {
    logic                     div;
    logic                     dz;
    logic [DEN_W-1:0]         den;
    lane_t                    re;
    lane_t                    im;
    logic signed [DATA_W-1:0] res_re;
    logic signed [DATA_W-1:0] res_im;
  } dpipe_t;

  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'((64'sd1 <<< (DATA_W - 1)) - 64'sd1);
    lo = -SUM_W'(64'sd1 <<< (DATA_W - 1));
    if (v > hi) begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return v[DATA_W-1:0];
    end
  endfunction

endpackage

FILE: rtl/core/cau_prod.sv
// First pipeline stage: the four cross products, the two divisor squares and add/subtract.
// Depends on cau_pkg.
`timescale 1ns / 1ps

module cau_prod (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  cau_pkg::in_item_t item,
  output logic              vld,
  output cau_pkg::prod_t    prod
);

  logic           vld_r;
  cau_pkg::prod_t prod_r;
  cau_pkg::prod_t prod_nxt;

  always_comb begin
    prod_nxt.op     = item.operation;
    prod_nxt.p_rr   = item.a_real * item.b_real;
    prod_nxt.p_ii   = item.a_imag * item.b_imag;
    prod_nxt.p_ri   = item.a_real * item.b_imag;
    prod_nxt.p_ir   = item.a_imag * item.b_real;
    prod_nxt.sq_r   = item.b_real * item.b_real;
    prod_nxt.sq_i   = item.b_imag * item.b_imag;
    if (item.operation == cau_pkg::OP_SUB) begin
      prod_nxt.s_re = {item.a_real[cau_pkg::DATA_W-1], item.a_real}
                    - {item.b_real[cau_pkg::DATA_W-1], item.b_real};
      prod_nxt.s_im = {item.a_imag[cau_pkg::DATA_W-1], item.a_imag}
                    - {item.b_imag[cau_pkg::DATA_W-1], item.b_imag};
    end else begin
      prod_nxt.s_re = {item.a_real[cau_pkg::DATA_W-1], item.a_real}
                    + {item.b_real[cau_pkg::DATA_W-1], item.b_real};
      prod_nxt.s_im = {item.a_imag[cau_pkg::DATA_W-1], item.a_imag}
                    + {item.b_imag[cau_pkg::DATA_W-1], item.b_imag};
    end
    prod_nxt.b_zero = (item.b_real == '0) && (item.b_imag == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign vld  = vld_r;
  assign prod = prod_r;

endmodule

FILE: rtl/core/cau_prep.sv
// Second stage logic: sums of products, final add/sub/multiply results and divider setup.
// Depends on cau_pkg; purely combinational, registered by the first divider step.
`timescale 1ns / 1ps

module cau_prep (
  input  cau_pkg::prod_t  prod,
  output cau_pkg::dpipe_t dp
);

  logic signed [cau_pkg::SUM_W-1:0] m_re;
  logic signed [cau_pkg::SUM_W-1:0] m_im;
  logic signed [cau_pkg::SUM_W-1:0] n_re;
  logic signed [cau_pkg::SUM_W-1:0] n_im;
  logic signed [cau_pkg::SUM_W-1:0] n_re_abs;
  logic signed [cau_pkg::SUM_W-1:0] n_im_abs;
  logic [cau_pkg::DEN_W-1:0]        mag_re;
  logic [cau_pkg::DEN_W-1:0]        mag_im;
  logic [cau_pkg::DEN_W-1:0]        den;

  always_comb begin
    m_re = {prod.p_rr[cau_pkg::PROD_W-1], prod.p_rr} - {prod.p_ii[cau_pkg::PROD_W-1], prod.p_ii};
    m_im = {prod.p_ri[cau_pkg::PROD_W-1], prod.p_ri} + {prod.p_ir[cau_pkg::PROD_W-1], prod.p_ir};
    n_re = {prod.p_rr[cau_pkg::PROD_W-1], prod.p_rr} + {prod.p_ii[cau_pkg::PROD_W-1], prod.p_ii};
    n_im = {prod.p_ir[cau_pkg::PROD_W-1], prod.p_ir} - {prod.p_ri[cau_pkg::PROD_W-1], prod.p_ri};
    n_re_abs = n_re[cau_pkg::SUM_W-1] ? -n_re : n_re;
    n_im_abs = n_im[cau_pkg::SUM_W-1] ? -n_im : n_im;
    mag_re   = n_re_abs[cau_pkg::DEN_W-1:0];
    mag_im   = n_im_abs[cau_pkg::DEN_W-1:0];
    den      = prod.sq_r[cau_pkg::DEN_W-1:0] + prod.sq_i[cau_pkg::DEN_W-1:0];

    dp.div = (prod.op == cau_pkg::OP_DIV);
    dp.dz  = (prod.op == cau_pkg::OP_DIV) && prod.b_zero;
    dp.den = den;

    // A quotient that reaches the top of the range is flagged to saturate; its divider result is not used.
    dp.re.rem = {{(cau_pkg::REM_W-cau_pkg::DEN_W-cau_pkg::FRAC_W){1'b0}}, mag_re,
                 {cau_pkg::FRAC_W{1'b0}}};
    dp.re.quo = '0;
    dp.re.neg = n_re[cau_pkg::SUM_W-1];
    dp.re.sat = {{(cau_pkg::QUO_W-cau_pkg::FRAC_W){1'b0}}, mag_re}
             >= {den, {(cau_pkg::QUO_W-cau_pkg::FRAC_W){1'b0}}};
    dp.im.rem = {{(cau_pkg::REM_W-cau_pkg::DEN_W-cau_pkg::FRAC_W){1'b0}}, mag_im,
                 {cau_pkg::FRAC_W{1'b0}}};
    dp.im.quo = '0;
    dp.im.neg = n_im[cau_pkg::SUM_W-1];
    dp.im.sat = {{(cau_pkg::QUO_W-cau_pkg::FRAC_W){1'b0}}, mag_im}
             >= {den, {(cau_pkg::QUO_W-cau_pkg::FRAC_W){1'b0}}};

    case (prod.op)
      cau_pkg::OP_MUL: begin
        dp.res_re = cau_pkg::sat_data(m_re >>> cau_pkg::FRAC_W);
        dp.res_im = cau_pkg::sat_data(m_im >>> cau_pkg::FRAC_W);
      end
      default: begin
        dp.res_re = cau_pkg::sat_data({{(cau_pkg::SUM_W-cau_pkg::DATA_W-1){prod.s_re[cau_pkg::DATA_W]}},
                                       prod.s_re});
        dp.res_im = cau_pkg::sat_data({{(cau_pkg::SUM_W-cau_pkg::DATA_W-1){prod.s_im[cau_pkg::DATA_W]}},
                                       prod.s_im});
      end
    endcase
  end

endmodule

FILE: rtl/core/cau_div_step.sv
// One registered step of the restoring divider: one quotient bit for each lane.
// Depends on cau_pkg.
`timescale 1ns / 1ps

module cau_div_step (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            vld_in,
  input  cau_pkg::dpipe_t dp_in,
  output logic            vld_out,
  output cau_pkg::dpipe_t dp_out
);

  logic                        vld_r;
  cau_pkg::dpipe_t             dp_r;
  cau_pkg::dpipe_t             dp_nxt;
  logic [cau_pkg::REM_W-1:0]   dsh;
  logic [cau_pkg::REM_W-1:0]   r_re;
  logic [cau_pkg::REM_W-1:0]   r_im;
  logic                        b_re;
  logic                        b_im;

  // The divisor stays aligned to the top quotient bit; the remainder shifts up instead.
  always_comb begin
    dsh  = {{(cau_pkg::REM_W-cau_pkg::DEN_W-cau_pkg::QUO_W+1){1'b0}}, dp_in.den,
            {(cau_pkg::QUO_W-1){1'b0}}};
    b_re = dp_in.re.rem >= dsh;
    b_im = dp_in.im.rem >= dsh;
    r_re = b_re ? dp_in.re.rem - dsh : dp_in.re.rem;
    r_im = b_im ? dp_in.im.rem - dsh : dp_in.im.rem;
    dp_nxt        = dp_in;
    dp_nxt.re.rem = {r_re[cau_pkg::REM_W-2:0], 1'b0};
    dp_nxt.im.rem = {r_im[cau_pkg::REM_W-2:0], 1'b0};
    dp_nxt.re.quo = {dp_in.re.quo[cau_pkg::QUO_W-2:0], b_re};
    dp_nxt.im.quo = {dp_in.im.quo[cau_pkg::QUO_W-2:0], b_im};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    dp_r <= dp_nxt;
  end

  assign vld_out = vld_r;
  assign dp_out  = dp_r;

endmodule

FILE: rtl/core/complex_arithmetic_unit_core.sv
// Top level of the complex arithmetic unit: product stage, divider pipeline, output stage.
// Depends on cau_pkg, cau_prod, cau_prep and cau_div_step.
//
//   channel  | ports                      | handshake
//   ---------+----------------------------+---------------------------------
//   input    | start, busy, in_item       | taken when start high, busy low
//   result   | out_valid, out_item        | one-cycle strobe, no back pressure
//
// While busy is low, one item enters per clock through 17 register stages (LAT in the
// package): one product stage, fifteen divider steps of one quotient bit each, one output
// stage. The product register loads at the accepting edge; the item then passes the divider
// steps and the output register, whose strobe marks the result.
// Every operation takes the same path, so results leave in order at the input rate.
// Reset clears the valid bits of all stages; busy is high only while reset is held.
// Results cannot be held off, so the pipeline never stalls.
`timescale 1ns / 1ps

module complex_arithmetic_unit_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  cau_pkg::in_item_t  in_item,
  output logic               out_valid,
  output cau_pkg::out_item_t out_item
);

  logic               acc;
  logic               p_vld;
  cau_pkg::prod_t     prod;
  logic               stg_v [0:cau_pkg::QUO_W];
  cau_pkg::dpipe_t    stg   [0:cau_pkg::QUO_W];
  logic               out_valid_r;
  cau_pkg::out_item_t out_r;
  cau_pkg::out_item_t out_nxt;
  cau_pkg::dpipe_t    fin;

  assign busy = ~rst_n;
  assign acc  = start && !busy;

  cau_prod u_prod (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .item  (in_item),
    .vld   (p_vld),
    .prod  (prod)
  );

  cau_prep u_prep (
    .prod (prod),
    .dp   (stg[0])
  );

  assign stg_v[0] = p_vld;

  for (genvar i = 0; i < cau_pkg::QUO_W; i++) begin : g_div
    cau_div_step u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .vld_in  (stg_v[i]),
      .dp_in   (stg[i]),
      .vld_out (stg_v[i+1]),
      .dp_out  (stg[i+1])
    );
  end

  assign fin = stg[cau_pkg::QUO_W];

  function automatic logic signed [cau_pkg::DATA_W-1:0] lane_out(input cau_pkg::lane_t l);
    if (l.sat) begin
      return l.neg ? {1'b1, {(cau_pkg::DATA_W-1){1'b0}}} : {1'b0, {(cau_pkg::DATA_W-1){1'b1}}};
    end else if (l.neg) begin
      return -{1'b0, l.quo};
    end else begin
      return {1'b0, l.quo};
    end
  endfunction

  always_comb begin
    out_nxt.divide_by_zero = fin.dz;
    if (fin.dz) begin
      out_nxt.result_real = '0;
      out_nxt.result_imag = '0;
    end else if (fin.div) begin
      out_nxt.result_real = lane_out(fin.re);
      out_nxt.result_imag = lane_out(fin.im);
    end else begin
      out_nxt.result_real = fin.res_re;
      out_nxt.result_imag = fin.res_im;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= stg_v[cau_pkg::QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // A valid product stage always traces back to an item taken in the previous cycle.
  a_prod_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    p_vld |-> $past(acc))
    else $error("product stage valid without an accepted item");

  // After all steps the remainder of an unsaturated quotient lies below the divisor.
  a_rem_re_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_v[cau_pkg::QUO_W] && fin.div && !fin.dz && !fin.re.sat) |->
      (fin.re.rem < {1'b0, fin.den, {cau_pkg::QUO_W{1'b0}}}))
    else $error("real divider remainder out of range");

  a_rem_im_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_v[cau_pkg::QUO_W] && fin.div && !fin.dz && !fin.im.sat) |->
      (fin.im.rem < {1'b0, fin.den, {cau_pkg::QUO_W{1'b0}}}))
    else $error("imaginary divider remainder out of range");

  // A divide by zero must come out as a zero result.
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.divide_by_zero) |->
      (out_item.result_real == '0 && out_item.result_imag == '0))
    else $error("divide by zero with nonzero result");

endmodule

FILE: tb/complex_arithmetic_unit_core_test.sv
// Self-checking bench for the complex arithmetic unit: add, subtract, multiply, divide.
// Depends on cau_pkg and complex_arithmetic_unit_core; expected results come from a local model.
`timescale 1ns / 1ps

module complex_arithmetic_unit_core_test;
  import cau_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  in_item_t  pending_ops[$];
  out_item_t awaited_results[$];
  int        errors = 0;
  int        send_idle_pct;
  bit        hold_off;
  bit        stim_done;

  complex_arithmetic_unit_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100000000;
    $display("** complex_arithmetic_unit_core: FAILED **");
    $finish;
  end

  function automatic logic signed [15:0] clamp16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Floor of v / 256.
  function automatic longint shift_floor(input longint v);
    return v >>> FRAC_W;
  endfunction

  // Truncation toward zero of v * 256 / den; den is positive.
  function automatic longint scaled_div(input longint v, input longint den);
    longint mag;
    longint q;
    mag = (v < 0) ? -v : v;
    q = (mag * 256) / den;
    return (v < 0) ? -q : q;
  endfunction

  function automatic out_item_t complex_result(input in_item_t it);
    out_item_t r;
    longint ar, ai, br, bi, den;
    ar = it.a_real; ai = it.a_imag; br = it.b_real; bi = it.b_imag;
    r = '0;
    case (it.operation)
      OP_ADD: begin
        r.result_real = clamp16(ar + br);
        r.result_imag = clamp16(ai + bi);
      end
      OP_SUB: begin
        r.result_real = clamp16(ar - br);
        r.result_imag = clamp16(ai - bi);
      end
      OP_MUL: begin
        r.result_real = clamp16(shift_floor(ar * br - ai * bi));
        r.result_imag = clamp16(shift_floor(ar * bi + ai * br));
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.divide_by_zero = 1'b1;
        end else begin
          r.result_real = clamp16(scaled_div(ar * br + ai * bi, den));
          r.result_imag = clamp16(scaled_div(ai * br - ar * bi, den));
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [15:0] rand_operand();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(0, 6)) - 3);
      4, 5: return 16'($signed($urandom_range(0, 1023)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_op(input logic [1:0] op, input logic [15:0] ar, input logic [15:0] ai,
                          input logic [15:0] br, input logic [15:0] bi);
    in_item_t it;
    it.operation = op; it.a_real = ar; it.a_imag = ai; it.b_real = br; it.b_imag = bi;
    pending_ops.push_back(it);
  endtask

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++) begin
      queue_op(2'($urandom_range(0, 3)), rand_operand(), rand_operand(),
               ($urandom_range(0, 15) == 0) ? 16'h0 : rand_operand(),
               ($urandom_range(0, 15) == 0) ? 16'h0 : rand_operand());
    end
  endtask

  task automatic drain();
    while (pending_ops.size() != 0 || awaited_results.size() != 0) @(posedge clk);
  endtask

  // Driver: one item per accepted edge, random gaps while send_idle_pct is nonzero.
  always @(posedge clk) begin
    if (!rst_n) begin
      start   <= 1'b0;
      in_item <= '0;
    end else begin
      if (start && !busy) begin
        awaited_results.push_back(complex_result(in_item));
        void'(pending_ops.pop_front());
      end
      if (!(start && busy) && !hold_off && pending_ops.size() != 0 &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        if (start && !busy) begin
          if (pending_ops.size() != 0) begin
            in_item <= pending_ops[0];
            start <= 1'b1;
          end else begin
            start <= 1'b0;
          end
        end else begin
          in_item <= pending_ops[0];
          start <= 1'b1;
        end
      end else if (!(start && busy)) begin
        start <= 1'b0;
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_item);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        if (want.result_real !== out_item.result_real ||
            want.result_imag !== out_item.result_imag ||
            want.divide_by_zero !== out_item.divide_by_zero) begin
          $display("%0t: mismatch expected re=%h im=%h dz=%b actual re=%h im=%h dz=%b",
                   $time, want.result_real, want.result_imag, want.divide_by_zero,
                   out_item.result_real, out_item.result_imag, out_item.divide_by_zero);
          errors++;
        end
      end
    end
  end

  initial begin
    hold_off = 1'b0;
    send_idle_pct = 30;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // Extremes, each operation, zero and tiny divisors, overflow on every path.
    queue_op(OP_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    queue_op(OP_ADD, 16'h0100, 16'hff00, 16'h0080, 16'h0001);
    queue_op(OP_SUB, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    queue_op(OP_SUB, 16'h8000, 16'h0000, 16'h0001, 16'hffff);
    queue_op(OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    queue_op(OP_MUL, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff);
    queue_op(OP_MUL, 16'hffff, 16'h0000, 16'h0001, 16'h0000);
    queue_op(OP_MUL, 16'h0100, 16'h0100, 16'h0100, 16'hff00);
    queue_op(OP_DIV, 16'h1234, 16'h5678, 16'h0000, 16'h0000);
    queue_op(OP_DIV, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
    queue_op(OP_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000);
    queue_op(OP_DIV, 16'h8000, 16'h7fff, 16'h0000, 16'hffff);
    queue_op(OP_DIV, 16'h0100, 16'h0000, 16'h0100, 16'h0000);
    queue_op(OP_DIV, 16'hff00, 16'h0080, 16'h0300, 16'hfd00);
    queue_op(OP_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    queue_op(OP_DIV, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    queue_op(OP_DIV, 16'h0001, 16'hffff, 16'h7fff, 16'h7fff);
    queue_op(OP_DIV, 16'hffff, 16'h0000, 16'h0003, 16'h0000);
    drain();
    // Hold the sender off until the pipeline has emptied.
    hold_off = 1'b1;
    repeat (LAT + 4) @(posedge clk);
    hold_off = 1'b0;
    queue_random(520);
    drain();
    send_idle_pct = 79;
    queue_random(520);
    drain();
    send_idle_pct = 0;
    queue_random(510);
    drain();
    repeat (LAT + 5) @(posedge clk);
    if (errors == 0) begin
      $display("** complex_arithmetic_unit_core: PASSED **");
    end else begin
      $display("** complex_arithmetic_unit_core: FAILED **");
    end
    $finish;
  end

endmodule

FILE: complex_arithmetic_unit_core.f
rtl/core/cau_pkg.sv
rtl/core/cau_prod.sv
rtl/core/cau_prep.sv
rtl/core/cau_div_step.sv
rtl/core/complex_arithmetic_unit_core.sv
tb/complex_arithmetic_unit_core_test.sv
